// ===== hw/rtl/lidar_range_image_projection_macros.svh =====
// Assertion macros for the lidar range image projection block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LIDAR_RANGE_IMAGE_PROJECTION_MACROS_SVH
`define LIDAR_RANGE_IMAGE_PROJECTION_MACROS_SVH

// Property checked at every clock edge outside reset.
`define LRIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication from one edge to the next, outside reset.
`define LRIP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/lrip_pkg.sv =====
// Shared types, constants and the arctangent table of the range image projection.
// No dependencies; imported by every cell module and by the top level.
package lrip_pkg;

  localparam int ROWS = 16;
  localparam int COLS = 1800;

  localparam int CoordW  = 20;
  localparam int RangeW  = 20;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam int SqrtSteps = 31;
  localparam int SqrtRadW  = 2 * SqrtSteps;
  localparam int SqrtRemW  = SqrtSteps + 2;

  localparam int CordicSteps = 20;
  localparam int CordicW     = 34;
  localparam int AccW        = 32;
  localparam int StepW       = 5;

  localparam int DivSteps = 22;
  localparam int DivDenW  = 17;

  typedef enum logic [1:0] {
    REG_BOTTOM_ANGLE,
    REG_VERT_RES,
    REG_HORIZ_RES,
    REG_MIN_RANGE
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                     pixel_valid;
    logic [6:0]               row_index;
    logic [11:0]              column_index;
    logic [18:0]              pixel_index;
    logic [RangeW-1:0]        point_range;
    logic signed [CoordW-1:0] echo_x;
    logic signed [CoordW-1:0] echo_y;
    logic signed [CoordW-1:0] echo_z;
  } pixel_t;

  typedef struct packed {
    logic [SqrtRadW-1:0]  rad;
    logic [SqrtRemW-1:0]  rem;
    logic [SqrtSteps-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CordicW-1:0] n;
    logic signed [CordicW-1:0] d;
    logic signed [AccW-1:0]    acc;
  } cordic_t;

  typedef struct packed {
    logic [DivSteps-1:0] num;
    logic [DivDenW-1:0]  rem;
    logic [DivSteps-1:0] quo;
  } div_t;

  // atan(2^-i) in 2^-20 degree.
  function automatic logic signed [AccW-1:0] atan_fine(input logic [StepW-1:0] i);
    logic signed [AccW-1:0] v;
    case (i)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/lrip_sqrt_cell.sv =====
// One digit of the pipelined integer square root: two radicand bits per cell.
// Depends on lrip_pkg.
module lrip_sqrt_cell (
  input  logic            clk_i,
  input  lrip_pkg::sqrt_t cell_i,
  output lrip_pkg::sqrt_t cell_o
);
  import lrip_pkg::*;

  logic [SqrtRemW+1:0] part;
  logic [SqrtRemW+1:0] trial;
  sqrt_t               cell_d;
  sqrt_t               cell_q;

  always_comb begin
    part       = {cell_i.rem, cell_i.rad[SqrtRadW-1 -: 2]};
    trial      = {2'b00, cell_i.root, 2'b01};
    cell_d.rad = {cell_i.rad[SqrtRadW-3:0], 2'b00};
    if (part >= trial) begin
      cell_d.rem  = SqrtRemW'(part - trial);
      cell_d.root = {cell_i.root[SqrtSteps-2:0], 1'b1};
    end else begin
      cell_d.rem  = SqrtRemW'(part);
      cell_d.root = {cell_i.root[SqrtSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/lrip_cordic_cell.sv =====
// One rotation of the vectoring arctangent pipeline.
// Depends on lrip_pkg for the word type and the arctangent table.
module lrip_cordic_cell (
  input  logic                        clk_i,
  input  logic [lrip_pkg::StepW-1:0]  step_i,
  input  lrip_pkg::cordic_t           cell_i,
  output lrip_pkg::cordic_t           cell_o
);
  import lrip_pkg::*;

  logic signed [CordicW-1:0] dn;
  logic signed [CordicW-1:0] nn;
  cordic_t                   cell_d;
  cordic_t                   cell_q;

  always_comb begin
    dn = cell_i.d >>> step_i;
    nn = cell_i.n >>> step_i;
    if (cell_i.n > 0) begin
      cell_d.d   = cell_i.d + nn;
      cell_d.n   = cell_i.n - dn;
      cell_d.acc = cell_i.acc + atan_fine(step_i);
    end else begin
      cell_d.d   = cell_i.d - nn;
      cell_d.n   = cell_i.n + dn;
      cell_d.acc = cell_i.acc - atan_fine(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/lrip_div_cell.sv =====
// One quotient bit of the pipelined restoring divider.
// Depends on lrip_pkg.
module lrip_div_cell (
  input  logic                          clk_i,
  input  logic [lrip_pkg::DivDenW-1:0]  den_i,
  input  lrip_pkg::div_t                cell_i,
  output lrip_pkg::div_t                cell_o
);
  import lrip_pkg::*;

  logic [DivDenW:0] part;
  div_t             cell_d;
  div_t             cell_q;

  always_comb begin
    part       = {cell_i.rem, cell_i.num[DivSteps-1]};
    cell_d.num = {cell_i.num[DivSteps-2:0], 1'b0};
    if (part >= {1'b0, den_i}) begin
      cell_d.rem = DivDenW'(part - {1'b0, den_i});
      cell_d.quo = {cell_i.quo[DivSteps-2:0], 1'b1};
    end else begin
      cell_d.rem = DivDenW'(part);
      cell_d.quo = {cell_i.quo[DivSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== hw/rtl/lidar_range_image_projection.sv =====
// Top level of the lidar range image projection: register port, pipeline control.
// Depends on lrip_pkg, lrip_sqrt_cell, lrip_cordic_cell, lrip_div_cell and the macro header.
//
// A point word (x, y, z) is taken at every rising edge where start is high and busy
// is low; busy stays low, so a new point may be given in every cycle. Each point
// yields one result word on result_o, marked by done_o for exactly one cycle.
// Results leave in arrival order. Between the accepting edge and the strobe there
// lies the chain of registered cells, in order: two squaring stages, 31 square
// root cells (one root bit each), a rotation stage and 20 arctangent cells, two
// angle stages, 22 divider cells (one quotient bit each) and the output stage.
// The receiver cannot stall; a result is on the ports for its one cycle only.
// The APB port holds bottom angle, vertical and horizontal resolution and minimum
// range at byte addresses 0, 4, 8 and 12; pready is always high. Write it only
// while no point is in flight. Reset clears the pipeline valid bits and the strobe
// and loads the register defaults.
`include "lidar_range_image_projection_macros.svh"

module lidar_range_image_projection (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  lrip_pkg::point_t             point_i,
  output logic                         done_o,
  output lrip_pkg::pixel_t             result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrip_pkg::AddrW-1:0]   paddr,
  input  logic [lrip_pkg::DataW-1:0]   pwdata,
  output logic [lrip_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import lrip_pkg::*;

  localparam int SqrtOut  = 2 + SqrtSteps;
  localparam int NumStage = SqrtOut + 1 + CordicSteps + 2;
  localparam int DivOut   = NumStage + DivSteps;
  localparam int RngDly   = DivOut - SqrtOut;
  localparam int Latency  = DivOut + 2;

  localparam logic signed [AccW-1:0] Deg180Fine = 32'sd188743680;
  localparam logic signed [22:0]     Deg90      = 23'sd368640;
  localparam logic signed [23:0]     ColsS      = 24'(COLS);
  localparam logic signed [23:0]     HalfColsS  = 24'(COLS / 2);

  typedef struct packed {
    logic el_zero;
    logic az_zero;
    logic az_half;
  } pre_t;

  typedef struct packed {
    logic              low;
    logic [RangeW-1:0] range;
  } rng_t;

  typedef struct packed {
    logic row_neg;
    logic col_neg;
  } dflag_t;

  // Configuration registers.
  logic [18:0] bottom_q;
  logic [15:0] vres_q;
  logic [15:0] hres_q;
  logic [19:0] minr_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_q <= 19'd61850;
      vres_q   <= 16'd8192;
      hres_q   <= 16'd819;
      minr_q   <= 20'd512;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BOTTOM_ANGLE: bottom_q <= pwdata[18:0];
        REG_VERT_RES:     vres_q   <= pwdata[15:0];
        REG_HORIZ_RES:    hres_q   <= pwdata[15:0];
        REG_MIN_RANGE:    minr_q   <= pwdata[19:0];
        default:          bottom_q <= bottom_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BOTTOM_ANGLE: prdata = DataW'(bottom_q);
      REG_VERT_RES:     prdata = DataW'(vres_q);
      REG_HORIZ_RES:    prdata = DataW'(hres_q);
      REG_MIN_RANGE:    prdata = DataW'(minr_q);
      default:          prdata = '0;
    endcase
  end

  logic [15:0]        vres_eff;
  logic [15:0]        hres_eff;
  logic [DivDenW-1:0] vden;
  logic [DivDenW-1:0] cden;

  assign vres_eff = (vres_q == '0) ? 16'd1 : vres_q;
  assign hres_eff = (hres_q == '0) ? 16'd1 : hres_q;
  assign vden     = {1'b0, vres_eff};
  assign cden     = {hres_eff, 1'b0};

  // Valid bits and point words travel alongside the cells.
  logic   v_q  [0:DivOut];
  point_t pt_q [0:DivOut];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivOut; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= start && !busy;
      for (int k = 1; k <= DivOut; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q[0] <= point_i;
    for (int k = 1; k <= DivOut; k++) begin
      pt_q[k] <= pt_q[k-1];
    end
  end

  // Squares and their sums.
  logic signed [2*CoordW-1:0] px;
  logic signed [2*CoordW-1:0] py;
  logic signed [2*CoordW-1:0] pz;
  logic [38:0]                xx_q;
  logic [38:0]                yy_q;
  logic [38:0]                zz_q;
  logic [39:0]                hsq_q;
  logic [40:0]                rsq_q;

  assign px = pt_q[0].point_x * pt_q[0].point_x;
  assign py = pt_q[0].point_y * pt_q[0].point_y;
  assign pz = pt_q[0].point_z * pt_q[0].point_z;

  always_ff @(posedge clk_i) begin
    xx_q  <= px[38:0];
    yy_q  <= py[38:0];
    zz_q  <= pz[38:0];
    hsq_q <= 40'(xx_q) + 40'(yy_q);
    rsq_q <= 41'(xx_q) + 41'(yy_q) + 41'(zz_q);
  end

  // Square root chains: horizontal distance in 2^-20 m and range in 2^-10 m.
  wire sqrt_t sh [0:SqrtSteps];
  wire sqrt_t sr [0:SqrtSteps];

  assign sh[0] = '{rad: {2'b00, hsq_q, 20'b0}, rem: '0, root: '0};
  assign sr[0] = '{rad: {21'b0, rsq_q}, rem: '0, root: '0};

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    lrip_sqrt_cell u_sqrt_h (.clk_i(clk_i), .cell_i(sh[k]), .cell_o(sh[k+1]));
    lrip_sqrt_cell u_sqrt_r (.clk_i(clk_i), .cell_i(sr[k]), .cell_o(sr[k+1]));
  end

  // Rotation into the right half plane and range checks.
  point_t                    pt_s;
  logic signed [CordicW-1:0] xs;
  logic signed [CordicW-1:0] ys;
  cordic_t                   el0_q;
  cordic_t                   az0_q;
  pre_t                      pre_q [0:CordicSteps];
  rng_t                      rd_q  [0:RngDly-1];

  assign pt_s = pt_q[SqrtOut];
  assign xs   = {{4{pt_s.point_x[CoordW-1]}}, pt_s.point_x, 10'b0};
  assign ys   = {{4{pt_s.point_y[CoordW-1]}}, pt_s.point_y, 10'b0};

  always_ff @(posedge clk_i) begin
    el0_q.n   <= {{4{pt_s.point_z[CoordW-1]}}, pt_s.point_z, 10'b0};
    el0_q.d   <= {3'b000, sh[SqrtSteps].root};
    el0_q.acc <= '0;
    if (pt_s.point_y < 0) begin
      az0_q.n   <= -xs;
      az0_q.d   <= -ys;
      az0_q.acc <= (pt_s.point_x >= 0) ? Deg180Fine : -Deg180Fine;
    end else begin
      az0_q.n   <= xs;
      az0_q.d   <= ys;
      az0_q.acc <= '0;
    end
    pre_q[0].el_zero <= (pt_s.point_z == '0);
    pre_q[0].az_zero <= (pt_s.point_x == '0);
    pre_q[0].az_half <= (pt_s.point_y < 0);
    for (int k = 1; k <= CordicSteps; k++) begin
      pre_q[k] <= pre_q[k-1];
    end
    rd_q[0].low   <= (sr[SqrtSteps].root < 31'(minr_q));
    rd_q[0].range <= (sr[SqrtSteps].root > 31'(20'hFFFFF)) ? 20'hFFFFF
                                                           : sr[SqrtSteps].root[RangeW-1:0];
    for (int k = 1; k < RngDly; k++) begin
      rd_q[k] <= rd_q[k-1];
    end
  end

  // Arctangent chains.
  wire cordic_t el_c [0:CordicSteps];
  wire cordic_t az_c [0:CordicSteps];

  assign el_c[0] = el0_q;
  assign az_c[0] = az0_q;

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    lrip_cordic_cell u_cordic_el (
      .clk_i (clk_i),
      .step_i(StepW'(k)),
      .cell_i(el_c[k]),
      .cell_o(el_c[k+1])
    );
    lrip_cordic_cell u_cordic_az (
      .clk_i (clk_i),
      .step_i(StepW'(k)),
      .cell_i(az_c[k]),
      .cell_o(az_c[k+1])
    );
  end

  // Angles in 1/4096 degree.
  pre_t                   pre_e;
  logic signed [AccW-1:0] el_acc;
  logic signed [AccW-1:0] az_acc;
  logic signed [AccW-1:0] el_rnd;
  logic signed [AccW-1:0] az_rnd;
  logic signed [21:0]     elev_q;
  logic signed [21:0]     azim_q;

  assign pre_e  = pre_q[CordicSteps];
  assign el_acc = pre_e.el_zero ? '0 : el_c[CordicSteps].acc;
  assign az_acc = pre_e.az_zero ? (pre_e.az_half ? Deg180Fine : '0) : az_c[CordicSteps].acc;
  assign el_rnd = (el_acc + 32'sd128) >>> 8;
  assign az_rnd = (az_acc + 32'sd128) >>> 8;

  always_ff @(posedge clk_i) begin
    elev_q <= el_rnd[21:0];
    azim_q <= az_rnd[21:0];
  end

  // Divider operands.
  logic signed [22:0] row_s;
  logic signed [22:0] col_s;
  logic signed [22:0] col_m;
  div_t               rdiv0_q;
  div_t               cdiv0_q;
  dflag_t             df_q [0:DivSteps];

  assign row_s = {elev_q[21], elev_q} + $signed({4'b0000, bottom_q});
  assign col_s = {azim_q[21], azim_q} - Deg90;
  assign col_m = col_s[22] ? -col_s : col_s;

  always_ff @(posedge clk_i) begin
    rdiv0_q.num <= row_s[22] ? '0 : row_s[21:0];
    rdiv0_q.rem <= '0;
    rdiv0_q.quo <= '0;
    cdiv0_q.num <= {col_m[20:0], 1'b0} + 22'(hres_eff);
    cdiv0_q.rem <= '0;
    cdiv0_q.quo <= '0;
    df_q[0].row_neg <= row_s[22];
    df_q[0].col_neg <= col_s[22];
    for (int k = 1; k <= DivSteps; k++) begin
      df_q[k] <= df_q[k-1];
    end
  end

  // Divider chains: row step and rounded column step.
  wire div_t rdv [0:DivSteps];
  wire div_t cdv [0:DivSteps];

  assign rdv[0] = rdiv0_q;
  assign cdv[0] = cdiv0_q;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    lrip_div_cell u_div_row (.clk_i(clk_i), .den_i(vden), .cell_i(rdv[k]), .cell_o(rdv[k+1]));
    lrip_div_cell u_div_col (.clk_i(clk_i), .den_i(cden), .cell_i(cdv[k]), .cell_o(cdv[k+1]));
  end

  // Pixel placement and result word.
  logic [DivSteps-1:0] rq;
  logic signed [23:0]  cq;
  logic signed [23:0]  c0;
  logic signed [23:0]  c1;
  logic                row_ok;
  logic                col_ok;
  logic                pix_ok;
  rng_t                rng_e;
  dflag_t              df_e;
  pixel_t              res_d;
  pixel_t              res_q;
  logic                done_q;

  assign rq    = rdv[DivSteps].quo;
  assign cq    = $signed({2'b00, cdv[DivSteps].quo});
  assign df_e  = df_q[DivSteps];
  assign rng_e = rd_q[RngDly-1];

  always_comb begin
    c0     = df_e.col_neg ? (HalfColsS + cq) : (HalfColsS - cq);
    c1     = (c0 >= ColsS) ? (c0 - ColsS) : c0;
    row_ok = !df_e.row_neg && (rq < DivSteps'(ROWS));
    col_ok = (c1 >= 0) && (c1 < ColsS);
    pix_ok = row_ok && col_ok && !rng_e.low;
    res_d.pixel_valid  = pix_ok;
    res_d.row_index    = pix_ok ? rq[6:0] : '0;
    res_d.column_index = pix_ok ? c1[11:0] : '0;
    res_d.pixel_index  = pix_ok ? (19'(c1[11:0]) + 19'(rq[6:0]) * 19'(COLS)) : '0;
    res_d.point_range  = rng_e.range;
    res_d.echo_x       = pt_q[DivOut].point_x;
    res_d.echo_y       = pt_q[DivOut].point_y;
    res_d.echo_z       = pt_q[DivOut].point_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_q[DivOut];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `LRIP_ASSERT(a_latency, (start && !busy) |-> ##Latency done_o, "accepted word lost")
  `LRIP_ASSERT_NEXT(a_out_from_pipe, v_q[DivOut], done_o, "strobe missing after last stage")
  `LRIP_ASSERT_NEXT(a_no_stray, !v_q[DivOut], !done_o, "strobe without a word in flight")
  `LRIP_ASSERT(a_in_image, (done_o && result_o.pixel_valid) |-> (result_o.row_index < 7'(ROWS) && result_o.column_index < 12'(COLS)), "valid pixel outside image")

endmodule
